/* hdl/mspid_pkg.sv */
// Shared types, constants and register codes of the motor speed PID block.
// Used by the channel interfaces, the filter and PID datapaths and the top level.
// No dependencies.
`default_nettype none

package mspid_pkg;

   // field widths
   localparam int unsigned CountWidth  = 16;
   localparam int unsigned TargetWidth = 16;
   localparam int unsigned WeightWidth = 16;
   localparam int unsigned GainWidth   = 16;
   localparam int unsigned LimitWidth  = 15;
   localparam int unsigned SpeedWidth  = 15;
   localparam int unsigned DutyWidth   = 15;
   localparam int unsigned LevelWidth  = 16;
   localparam int unsigned ErrorWidth  = 18;
   localparam int unsigned AccumWidth  = 25;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned HistDepth   = 3;

   // arithmetic constants
   localparam int unsigned FracBits    = 8;
   localparam int unsigned WeightFrac  = 15;
   localparam int unsigned SpeedScale  = 15;
   localparam int unsigned SpeedMax    = 32767;
   localparam int unsigned StartOutput = 0;

   // register reset values
   localparam logic [WeightWidth-1:0] WeightNewestReset   = 16'd16384;
   localparam logic [WeightWidth-1:0] WeightPreviousReset = 16'd8192;
   localparam logic [WeightWidth-1:0] WeightOldestReset   = 16'd8192;
   localparam logic signed [GainWidth-1:0] GainPropReset  = 16'sd256;
   localparam logic signed [GainWidth-1:0] GainIntegReset = 16'sd0;
   localparam logic signed [GainWidth-1:0] GainDerivReset = 16'sd0;
   localparam logic [LimitWidth-1:0] OutputLimitReset     = 15'd10000;
   localparam logic signed [AccumWidth-1:0] AccumReset =
      AccumWidth'(StartOutput * (1 << FracBits));

   // item kinds
   localparam logic OpEncoder = 1'b0;
   localparam logic OpTick    = 1'b1;

   // register map
   typedef enum logic [CsrIdxWidth-1:0] {
      REG_WEIGHT_NEWEST   = 3'd0,
      REG_WEIGHT_PREVIOUS = 3'd1,
      REG_WEIGHT_OLDEST   = 3'd2,
      REG_GAIN_PROP       = 3'd3,
      REG_GAIN_INTEG      = 3'd4,
      REG_GAIN_DERIV      = 3'd5,
      REG_OUTPUT_LIMIT    = 3'd6,
      REG_STALL_GUARD_ON  = 3'd7
   } csr_index_type;

   // count history, entry 0 newest
   typedef logic [HistDepth-1:0][SpeedWidth-1:0] hist_type;

   // controller state carried from tick to tick
   typedef struct packed {
      logic signed [AccumWidth-1:0] accum;
      logic signed [ErrorWidth-1:0] err_last;
      logic signed [ErrorWidth-1:0] err_before;
      logic                         fault;
   } pid_state_type;

   // drive values reported with each result word
   typedef struct packed {
      logic [DutyWidth-1:0]         duty;
      logic signed [LevelWidth-1:0] level;
   } pid_report_type;

endpackage

`default_nettype wire

/* hdl/mspid_req_if.sv */
// Request channel of the motor speed PID block: valid/ready plus one item.
// Depends on mspid_pkg for field widths.
`default_nettype none

interface mspid_req_if;
   logic                                             valid;
   logic                                             ready;
   logic                                             operation;
   logic signed [mspid_pkg::CountWidth-1:0]          encoder_count;
   logic signed [mspid_pkg::TargetWidth-1:0]         speed_target;

   modport source (output valid, output operation, output encoder_count,
                   output speed_target, input ready);
   modport sink   (input valid, input operation, input encoder_count,
                   input speed_target, output ready);
endinterface

`default_nettype wire

/* hdl/mspid_rsp_if.sv */
// Result channel of the motor speed PID block: valid/ready plus one result.
// Depends on mspid_pkg for field widths.
`default_nettype none

interface mspid_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic [mspid_pkg::DutyWidth-1:0]           pwm_duty;
   logic signed [mspid_pkg::LevelWidth-1:0]   drive_level;
   logic [mspid_pkg::SpeedWidth-1:0]          measured_speed;
   logic                                      stall_fault;

   modport source (output valid, output pwm_duty, output drive_level,
                   output measured_speed, output stall_fault, input ready);
   modport sink   (input valid, input pwm_duty, input drive_level,
                   input measured_speed, input stall_fault, output ready);
endinterface

`default_nettype wire

/* hdl/motor_speed_incremental_pid.sv */
// Top level of the motor speed incremental PID block.
// Depends on mspid_pkg, mspid_req_if, mspid_rsp_if, mspid_filter and mspid_pid.
`default_nettype none

// Takes one word per clock while the result register is free and returns one
// result word for each: a word goes into the input register, then the filter
// or PID update runs and writes both the controller state and the result
// register. The state update (three parallel multiplies, sum and clamp) is
// combinational from the input register, which is what allows a word in every
// cycle. req ready stays high while the result register is empty or being
// taken; one word can wait in the input register while a result is held.
// Configuration writes must only be issued with no word in flight.
module motor_speed_incremental_pid (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   mspid_req_if.sink                                    req_ch,
   mspid_rsp_if.source                                  rsp_ch,
   input  wire logic                                    csr_write_en,
   input  wire logic [mspid_pkg::CsrIdxWidth-1:0]       csr_index,
   input  wire logic [mspid_pkg::CsrDataWidth-1:0]      csr_write_data
);

   // configuration registers
   logic [mspid_pkg::WeightWidth-1:0]       weight_newest_ff;
   logic [mspid_pkg::WeightWidth-1:0]       weight_previous_ff;
   logic [mspid_pkg::WeightWidth-1:0]       weight_oldest_ff;
   logic signed [mspid_pkg::GainWidth-1:0]  gain_prop_ff;
   logic signed [mspid_pkg::GainWidth-1:0]  gain_integ_ff;
   logic signed [mspid_pkg::GainWidth-1:0]  gain_deriv_ff;
   logic [mspid_pkg::LimitWidth-1:0]        output_limit_ff;
   logic                                    stall_guard_on_ff;

   // input register
   logic                                    in_valid_ff;
   logic                                    in_valid_in;
   logic                                    in_op_ff;
   logic signed [mspid_pkg::CountWidth-1:0] in_count_ff;
   logic signed [mspid_pkg::TargetWidth-1:0] in_target_ff;

   // controller state
   mspid_pkg::hist_type                     hist_ff;
   mspid_pkg::hist_type                     hist_in;
   logic [mspid_pkg::SpeedWidth-1:0]        speed_ff;
   logic [mspid_pkg::SpeedWidth-1:0]        speed_in;
   mspid_pkg::pid_state_type                pid_ff;
   mspid_pkg::pid_state_type                pid_in;

   // result register
   logic                                    out_valid_ff;
   logic                                    out_valid_in;
   logic [mspid_pkg::DutyWidth-1:0]         out_duty_ff;
   logic signed [mspid_pkg::LevelWidth-1:0] out_level_ff;
   logic [mspid_pkg::SpeedWidth-1:0]        out_speed_ff;
   logic                                    out_fault_ff;

   logic                                    res_free;
   logic                                    advance;
   logic                                    req_take;
   logic                                    is_tick;
   mspid_pkg::hist_type                     filt_hist;
   logic [mspid_pkg::SpeedWidth-1:0]        filt_speed;
   mspid_pkg::pid_report_type               report;

   // handshake
   assign res_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && res_free;
   assign req_ch.ready = !in_valid_ff || res_free;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign is_tick      = (in_op_ff == mspid_pkg::OpTick);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // encoder filter
   mspid_filter u_filter (
      .count           (in_count_ff),
      .hist_now        (hist_ff),
      .weight_newest   (weight_newest_ff),
      .weight_previous (weight_previous_ff),
      .weight_oldest   (weight_oldest_ff),
      .hist_next       (filt_hist),
      .speed_next      (filt_speed)
   );

   // pid update
   mspid_pid u_pid (
      .tick           (is_tick),
      .speed_target   (in_target_ff),
      .speed_now      (speed_ff),
      .gain_prop      (gain_prop_ff),
      .gain_integ     (gain_integ_ff),
      .gain_deriv     (gain_deriv_ff),
      .output_limit   (output_limit_ff),
      .stall_guard_on (stall_guard_on_ff),
      .state_now      (pid_ff),
      .state_next     (pid_in),
      .report         (report)
   );

   // filter state only moves on encoder words
   assign hist_in  = is_tick ? hist_ff  : filt_hist;
   assign speed_in = is_tick ? speed_ff : filt_speed;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_newest_ff   <= mspid_pkg::WeightNewestReset;
         weight_previous_ff <= mspid_pkg::WeightPreviousReset;
         weight_oldest_ff   <= mspid_pkg::WeightOldestReset;
         gain_prop_ff       <= mspid_pkg::GainPropReset;
         gain_integ_ff      <= mspid_pkg::GainIntegReset;
         gain_deriv_ff      <= mspid_pkg::GainDerivReset;
         output_limit_ff    <= mspid_pkg::OutputLimitReset;
         stall_guard_on_ff  <= 1'b0;
      end else if (csr_write_en) begin
         unique case (mspid_pkg::csr_index_type'(csr_index))
            mspid_pkg::REG_WEIGHT_NEWEST:   weight_newest_ff   <= csr_write_data;
            mspid_pkg::REG_WEIGHT_PREVIOUS: weight_previous_ff <= csr_write_data;
            mspid_pkg::REG_WEIGHT_OLDEST:   weight_oldest_ff   <= csr_write_data;
            mspid_pkg::REG_GAIN_PROP:       gain_prop_ff       <= $signed(csr_write_data);
            mspid_pkg::REG_GAIN_INTEG:      gain_integ_ff      <= $signed(csr_write_data);
            mspid_pkg::REG_GAIN_DERIV:      gain_deriv_ff      <= $signed(csr_write_data);
            mspid_pkg::REG_OUTPUT_LIMIT:
               output_limit_ff <= csr_write_data[mspid_pkg::LimitWidth-1:0];
            mspid_pkg::REG_STALL_GUARD_ON:  stall_guard_on_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // handshake control and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         hist_ff      <= '0;
         speed_ff     <= '0;
         pid_ff       <= '{accum: mspid_pkg::AccumReset, err_last: '0,
                           err_before: '0, fault: 1'b0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            hist_ff  <= hist_in;
            speed_ff <= speed_in;
            pid_ff   <= pid_in;
         end
      end
   end

   // word payload and result payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff     <= req_ch.operation;
         in_count_ff  <= req_ch.encoder_count;
         in_target_ff <= req_ch.speed_target;
      end
      if (advance) begin
         out_duty_ff  <= report.duty;
         out_level_ff <= report.level;
         out_speed_ff <= speed_in;
         out_fault_ff <= pid_in.fault;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.pwm_duty       = out_duty_ff;
   assign rsp_ch.drive_level    = out_level_ff;
   assign rsp_ch.measured_speed = out_speed_ff;
   assign rsp_ch.stall_fault    = out_fault_ff;

endmodule

`default_nettype wire

/* hdl/mspid_filter.sv */
// Encoder speed filter: count magnitude, history shift, weighted sum, scale.
// Purely combinational; depends on mspid_pkg.
`default_nettype none

module mspid_filter (
   input  wire logic signed [mspid_pkg::CountWidth-1:0]  count,
   input  wire mspid_pkg::hist_type                      hist_now,
   input  wire logic [mspid_pkg::WeightWidth-1:0]        weight_newest,
   input  wire logic [mspid_pkg::WeightWidth-1:0]        weight_previous,
   input  wire logic [mspid_pkg::WeightWidth-1:0]        weight_oldest,
   output      mspid_pkg::hist_type                      hist_next,
   output      logic [mspid_pkg::SpeedWidth-1:0]         speed_next
);

   localparam int unsigned ProdWidth  = mspid_pkg::SpeedWidth + mspid_pkg::WeightWidth;
   localparam int unsigned SumWidth   = ProdWidth + 2;
   localparam int unsigned IntWidth   = SumWidth - mspid_pkg::WeightFrac;
   localparam int unsigned ScaleWidth = IntWidth + 4;

   logic [mspid_pkg::CountWidth-1:0] mag_full;
   logic [mspid_pkg::SpeedWidth-1:0] mag;
   logic [ProdWidth-1:0]             prod_new;
   logic [ProdWidth-1:0]             prod_prev;
   logic [ProdWidth-1:0]             prod_old;
   logic [SumWidth-1:0]              wsum;
   logic [IntWidth-1:0]              wint;
   logic [ScaleWidth-1:0]            scaled;

   // magnitude, most negative count saturates
   always_comb begin
      mag_full = count[mspid_pkg::CountWidth-1] ? (~count + 1'b1) : count;
      mag = mag_full[mspid_pkg::CountWidth-1] ?
            mspid_pkg::SpeedWidth'(mspid_pkg::SpeedMax) :
            mag_full[mspid_pkg::SpeedWidth-1:0];
   end

   // shift history, newest in entry 0
   assign hist_next[0] = mag;
   assign hist_next[1] = hist_now[0];
   assign hist_next[2] = hist_now[1];

   // weighted sum in Q1.15, integer part times scale, saturated
   always_comb begin
      prod_new  = ProdWidth'(hist_next[0]) * ProdWidth'(weight_newest);
      prod_prev = ProdWidth'(hist_next[1]) * ProdWidth'(weight_previous);
      prod_old  = ProdWidth'(hist_next[2]) * ProdWidth'(weight_oldest);
      wsum   = SumWidth'(prod_new) + SumWidth'(prod_prev) + SumWidth'(prod_old);
      wint   = wsum[SumWidth-1:mspid_pkg::WeightFrac];
      scaled = ScaleWidth'(wint) * ScaleWidth'(mspid_pkg::SpeedScale);
      if (scaled > ScaleWidth'(mspid_pkg::SpeedMax)) begin
         speed_next = mspid_pkg::SpeedWidth'(mspid_pkg::SpeedMax);
      end else begin
         speed_next = scaled[mspid_pkg::SpeedWidth-1:0];
      end
   end

endmodule

`default_nettype wire

/* hdl/mspid_pid.sv */
// Incremental PID update with stall protection and output clamp, plus the
// duty and drive level derived from the resulting accumulator. Combinational.
// Depends on mspid_pkg.
`default_nettype none

module mspid_pid (
   input  wire logic                                      tick,
   input  wire logic signed [mspid_pkg::TargetWidth-1:0]  speed_target,
   input  wire logic [mspid_pkg::SpeedWidth-1:0]          speed_now,
   input  wire logic signed [mspid_pkg::GainWidth-1:0]    gain_prop,
   input  wire logic signed [mspid_pkg::GainWidth-1:0]    gain_integ,
   input  wire logic signed [mspid_pkg::GainWidth-1:0]    gain_deriv,
   input  wire logic [mspid_pkg::LimitWidth-1:0]          output_limit,
   input  wire logic                                      stall_guard_on,
   input  wire mspid_pkg::pid_state_type                  state_now,
   output      mspid_pkg::pid_state_type                  state_next,
   output      mspid_pkg::pid_report_type                 report
);

   localparam int unsigned EW   = mspid_pkg::ErrorWidth;
   localparam int unsigned GW   = mspid_pkg::GainWidth;
   localparam int unsigned AW   = mspid_pkg::AccumWidth;
   localparam int unsigned PW   = EW + 1;           // first difference
   localparam int unsigned DW   = EW + 2;           // second difference
   localparam int unsigned ProdPW = GW + PW;
   localparam int unsigned ProdIW = GW + EW;
   localparam int unsigned ProdDW = GW + DW;
   localparam int unsigned IncW = ProdDW + 2;
   localparam int unsigned SumW = IncW + 1;
   localparam int unsigned LimW = mspid_pkg::LimitWidth + mspid_pkg::FracBits;

   logic                     stall;
   logic signed [EW-1:0]     err0;
   logic signed [PW-1:0]     diff_p;
   logic signed [DW-1:0]     diff_d;
   logic signed [ProdPW-1:0] prod_p;
   logic signed [ProdIW-1:0] prod_i;
   logic signed [ProdDW-1:0] prod_d;
   logic signed [IncW-1:0]   inc;
   logic signed [SumW-1:0]   acc_sum;
   logic signed [SumW-1:0]   lim;
   logic signed [AW-1:0]     acc_clamped;
   logic signed [AW-1:0]     acc_round;
   logic signed [AW-1:0]     acc_int;
   logic [LimW-1:0]          lim_q;

   // stall check sees the speed and accumulator held before this tick
   assign stall = stall_guard_on && (speed_now == '0) && (state_now.accum != '0);

   // error terms
   always_comb begin
      err0   = EW'(speed_target) - $signed(EW'(speed_now));
      diff_p = PW'(err0) - PW'(state_now.err_last);
      diff_d = DW'(err0) - (DW'(state_now.err_last) <<< 1) + DW'(state_now.err_before);
   end

   // three products and the signed Q29.8 increment
   always_comb begin
      prod_p = ProdPW'(gain_prop)  * ProdPW'(diff_p);
      prod_i = ProdIW'(gain_integ) * ProdIW'(err0);
      prod_d = ProdDW'(gain_deriv) * ProdDW'(diff_d);
      inc    = IncW'(prod_p) + IncW'(prod_i) + IncW'(prod_d);
   end

   // accumulate and clamp to plus or minus the limit
   always_comb begin
      lim_q   = {output_limit, mspid_pkg::FracBits'(0)};
      lim     = $signed({1'b0, (SumW-1)'(lim_q)});
      acc_sum = SumW'(state_now.accum) + SumW'(inc);
      if (acc_sum > lim) begin
         acc_clamped = AW'(lim);
      end else if (acc_sum < -lim) begin
         acc_clamped = AW'(-lim);
      end else begin
         acc_clamped = AW'(acc_sum);
      end
   end

   // next state: faulted ticks and encoder words leave it alone
   always_comb begin
      state_next = state_now;
      if (tick && !state_now.fault) begin
         if (stall) begin
            state_next.fault = 1'b1;
         end else begin
            state_next.accum      = acc_clamped;
            state_next.err_before = state_now.err_last;
            state_next.err_last   = err0;
         end
      end
   end

   // integer part truncated toward zero, duty zero when negative or faulted
   always_comb begin
      acc_round = state_next.accum[AW-1] ?
                  state_next.accum + AW'((1 << mspid_pkg::FracBits) - 1) :
                  state_next.accum;
      acc_int = acc_round >>> mspid_pkg::FracBits;
      report.level = acc_int[mspid_pkg::LevelWidth-1:0];
      if (state_next.fault || state_next.accum[AW-1]) begin
         report.duty = '0;
      end else begin
         report.duty = acc_int[mspid_pkg::DutyWidth-1:0];
      end
   end

endmodule

`default_nettype wire

/* hdl/mspid_checker.sv */
// Port-level checks of the motor speed PID block and the bind that attaches
// them to motor_speed_incremental_pid. Depends on mspid_pkg.
`default_nettype none

module mspid_checker (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    rsp_valid,
   input  wire logic                                    rsp_ready,
   input  wire logic [mspid_pkg::DutyWidth-1:0]         pwm_duty,
   input  wire logic signed [mspid_pkg::LevelWidth-1:0] drive_level,
   input  wire logic [mspid_pkg::SpeedWidth-1:0]        measured_speed,
   input  wire logic                                    stall_fault
);

   logic seen_fault_ff;

   // remember a fault once it has been reported
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_fault_ff <= 1'b0;
      end else if (rsp_valid && stall_fault) begin
         seen_fault_ff <= 1'b1;
      end
   end

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // fault stays latched until reset
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && seen_fault_ff) |-> stall_fault)
      else $error("stall fault cleared without reset");

   // duty matches the drive level: zero when faulted, else the non-negative level
   a_duty_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && stall_fault) |-> (pwm_duty == '0))
      else $error("duty not zero under stall fault");

   a_duty_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !stall_fault && !drive_level[mspid_pkg::LevelWidth-1]) |->
      (pwm_duty == drive_level[mspid_pkg::DutyWidth-1:0]))
      else $error("duty does not follow drive level");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(pwm_duty) &&
      $stable(drive_level) && $stable(measured_speed) && $stable(stall_fault)))
      else $error("stalled result changed");

endmodule

bind motor_speed_incremental_pid mspid_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .pwm_duty       (rsp_ch.pwm_duty),
   .drive_level    (rsp_ch.drive_level),
   .measured_speed (rsp_ch.measured_speed),
   .stall_fault    (rsp_ch.stall_fault)
);

`default_nettype wire
